// ----- design/sfra_pkg.sv -----
// sfra_pkg: shared constants and types of the shared fork ring arbiter
// command codes, job kinds and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package sfra_pkg;

  localparam int Seats      = 5;
  localparam int MaxResults = 2;

  localparam int CmdW  = 2;
  localparam int SeatW = 3;

  localparam logic [CmdW-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CmdW-1:0] CMD_TOGGLE  = 2'd2;

  // work that follows an accepted command
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_REL  = 2'd2;
  localparam logic [1:0] KIND_SCAN = 2'd3;

  typedef struct packed {
    logic       start;
    logic       try_en;
    logic [1:0] mode;
    logic       flush_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       stall;
    logic       flush_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/sfra_ctrl.sv -----
// sfra_ctrl: controller state machine of the shared fork ring arbiter
// sequences the candidate seats of one command; depends on sfra_pkg
`default_nettype none

module sfra_ctrl #(
  parameter int SEATS = sfra_pkg::Seats,
  parameter int SW    = $clog2(SEATS)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  sfra_pkg::dp_status_t    status,
  output sfra_pkg::ctrl_cmd_t     cmd,
  output logic [SW-1:0]           step
);
  import sfra_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TRY   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          last_step;

  always_comb begin
    case (mode_r)
      KIND_REL:  last_step = (step_r == SW'(1));
      KIND_SCAN: last_step = (step_r == SW'(SEATS - 1));
      default:   last_step = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.try_en   = 1'b0;
    cmd.flush_en = 1'b0;
    cmd.mode     = mode_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid && status.kind != KIND_NONE) begin
          state_nxt = ST_TRY;
          mode_nxt  = status.kind;
          step_nxt  = '0;
        end
      end
      ST_TRY: begin
        cmd.try_en = 1'b1;
        if (!status.stall) begin
          if (last_step) begin
            state_nxt = ST_FLUSH;
          end else begin
            step_nxt = step_r + SW'(1);
          end
        end
      end
      ST_FLUSH: begin
        cmd.flush_en = 1'b1;
        if (status.flush_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign step = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= KIND_NONE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sfra_datapath.sv -----
// sfra_datapath: fork, waiting and pause state, grant check and result register
// one grant is held back so the last one of a command can be flagged; depends on sfra_pkg
`default_nettype none

module sfra_datapath #(
  parameter int SEATS = sfra_pkg::Seats,
  parameter int SW    = $clog2(SEATS)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire [sfra_pkg::CmdW-1:0]       in_command,
  input  wire [sfra_pkg::SeatW-1:0]      in_seat,
  input  sfra_pkg::ctrl_cmd_t            cmd,
  input  wire [SW-1:0]                   step,
  output sfra_pkg::dp_status_t           status,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [sfra_pkg::SeatW-1:0]     out_granted_seat,
  output logic                           out_last_grant
);
  import sfra_pkg::*;

  localparam int CntW = $clog2(MaxResults + 1);
  localparam logic [SW-1:0] TopSeat = SW'(SEATS - 1);

  logic [SEATS-1:0] fork_used_r, fork_used_nxt;
  logic [SEATS-1:0] waiting_r, waiting_nxt;
  logic             paused_r, paused_nxt;
  logic [SW-1:0]    seat_r;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [SW-1:0]    pend_seat_r, pend_seat_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SW-1:0]    out_seat_r, out_seat_nxt;
  logic             out_last_r, out_last_nxt;

  logic          in_range;
  logic [SW-1:0] in_idx, in_up;
  logic [SW-1:0] cand, cand_up, seat_lo, seat_up;
  logic          need_wait, grant_ok, out_free;

  assign in_range = (32'(in_seat) < SEATS);
  assign in_idx   = SW'(in_seat);
  assign in_up    = (in_idx == TopSeat) ? '0 : in_idx + SW'(1);

  assign seat_lo = (seat_r == '0) ? TopSeat : seat_r - SW'(1);
  assign seat_up = (seat_r == TopSeat) ? '0 : seat_r + SW'(1);

  always_comb begin
    case (cmd.mode)
      KIND_REL: begin
        cand      = (step == '0) ? seat_lo : seat_up;
        need_wait = 1'b1;
      end
      KIND_SCAN: begin
        cand      = step;
        need_wait = 1'b1;
      end
      default: begin
        cand      = seat_r;
        need_wait = 1'b0;
      end
    endcase
  end

  assign cand_up  = (cand == TopSeat) ? '0 : cand + SW'(1);
  assign grant_ok = (count_r < CntW'(MaxResults)) && (!need_wait || waiting_r[cand]) &&
                    !fork_used_r[cand] && !fork_used_r[cand_up];
  assign out_free = !out_valid_r || out_ready;

  // decode of the command on the input port, used in the idle cycle, and the stall and flush status
  always_comb begin
    status.kind       = KIND_NONE;
    // a second grant must push the held one out first
    status.stall      = grant_ok && pend_valid_r && !out_free;
    status.flush_done = !pend_valid_r || out_free;
    case (in_command)
      CMD_REQUEST: begin
        if (in_range && !waiting_r[in_idx] && !paused_r) status.kind = KIND_REQ;
      end
      CMD_RELEASE: begin
        if (in_range && !paused_r) status.kind = KIND_REL;
      end
      CMD_TOGGLE: begin
        if (paused_r) status.kind = KIND_SCAN;
      end
      default: begin
        status.kind = KIND_NONE;
      end
    endcase
  end

  always_comb begin
    fork_used_nxt  = fork_used_r;
    waiting_nxt    = waiting_r;
    paused_nxt     = paused_r;
    count_nxt      = count_r;
    pend_valid_nxt = pend_valid_r;
    pend_seat_nxt  = pend_seat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_seat_nxt   = out_seat_r;
    out_last_nxt   = out_last_r;

    if (cmd.start) begin
      count_nxt = '0;
      case (in_command)
        CMD_REQUEST: begin
          if (in_range && !waiting_r[in_idx] && paused_r) waiting_nxt[in_idx] = 1'b1;
        end
        CMD_RELEASE: begin
          if (in_range) begin
            fork_used_nxt[in_idx] = 1'b0;
            fork_used_nxt[in_up]  = 1'b0;
          end
        end
        CMD_TOGGLE: begin
          paused_nxt = !paused_r;
        end
        default: begin
          paused_nxt = paused_r;
        end
      endcase
    end

    if (cmd.try_en && !status.stall) begin
      if (grant_ok) begin
        fork_used_nxt[cand]    = 1'b1;
        fork_used_nxt[cand_up] = 1'b1;
        waiting_nxt[cand]      = 1'b0;
        count_nxt              = count_r + CntW'(1);
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_seat_nxt  = pend_seat_r;
          out_last_nxt  = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_seat_nxt  = cand;
      end else if (cmd.mode == KIND_REQ) begin
        waiting_nxt[cand] = 1'b1;
      end
    end

    if (cmd.flush_en && pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_seat_nxt   = pend_seat_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fork_used_r  <= '0;
      waiting_r    <= '0;
      paused_r     <= 1'b0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fork_used_r  <= fork_used_nxt;
      waiting_r    <= waiting_nxt;
      paused_r     <= paused_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) seat_r <= in_idx;
    pend_seat_r <= pend_seat_nxt;
    out_seat_r  <= out_seat_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_seat = SeatW'(out_seat_r);
  assign out_last_grant   = out_last_r;

endmodule

`default_nettype wire

// ----- design/shared_fork_ring_arbiter.sv -----
// shared_fork_ring_arbiter: top level of the ring fork arbiter
// joins sfra_ctrl and sfra_datapath; depends on sfra_pkg
//
// usage:
//   input channel in_valid/in_ready carries in_command (request, release,
//   toggle pause) and in_seat. output channel out_valid/out_ready carries
//   one transfer per grant: out_granted_seat and out_last_grant, the latter
//   set on the last grant caused by one command.
// timing:
//   a command is taken in the idle cycle, then the controller tries one
//   candidate seat per cycle unless stalled: one for a request, two for a
//   release and SEATS for a resume scan, then a flush state sends out the
//   held grant, if any. commands that cause no work stay in the idle state.
//   the first grant of a command passes the held-grant register and the
//   output register before it appears.
// reset:
//   rst_n low frees all forks, clears all waiting bits and the pause flag.
// stall:
//   one grant waits in the output register while the next is held inside;
//   a third one holds the candidate loop until the receiver takes a result.
`default_nettype none

module shared_fork_ring_arbiter #(
  parameter int SEATS = sfra_pkg::Seats
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [sfra_pkg::CmdW-1:0]     in_command,
  input  wire [sfra_pkg::SeatW-1:0]    in_seat,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [sfra_pkg::SeatW-1:0]   out_granted_seat,
  output logic                         out_last_grant
);
  import sfra_pkg::*;

  localparam int SW = $clog2(SEATS);

  ctrl_cmd_t     cmd;
  dp_status_t    status;
  logic [SW-1:0] step;

  sfra_ctrl #(
    .SEATS (SEATS),
    .SW    (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .step     (step)
  );

  sfra_datapath #(
    .SEATS (SEATS),
    .SW    (SW)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_seat          (in_seat),
    .cmd              (cmd),
    .step             (step),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_seat (out_granted_seat),
    .out_last_grant   (out_last_grant)
  );

endmodule

`default_nettype wire
